// File: rtl/ffsra_pkg.sv
// Shared types and codes for the first-fit slot and room allocator.
// Used by ffsra_ctrl, ffsra_datapath and first_fit_slot_room_allocator_top.
package ffsra_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROOMS = 2'd1;

  localparam logic [6:0] NUM_SLOTS_RESET = 7'd64;
  localparam logic [4:0] NUM_ROOMS_RESET = 5'd16;

  // Result status codes
  localparam logic [1:0] STATUS_PLACED  = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
  localparam logic [1:0] STATUS_CLEARED = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] course_code;
    logic [5:0]  teacher_idx;
    logic [2:0]  year_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] course_out;
    logic [3:0]  room_index;
    logic [6:0]  slot_num;
  } rsp_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_BASE,
    S_SCAN,
    S_WRITE
  } ctl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic       sweep_en;
    logic       req_load;
    logic       base_load;
    logic       room_next;
    logic       hit_load;
    logic       write_en;
    logic       out_load;
    logic [1:0] out_status;
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_clear;
    logic range_ok;
    logic base_zero;
    logic rooms_zero;
    logic hit;
    logic last_room;
    logic sweep_done;
  } ctl_sts_t;

endpackage

// File: rtl/ffsra_ctrl.sv
// Sequencing state machine of the allocator: sweep, lookup, room scan, write back.
// Depends on ffsra_pkg (state enum, command/status structs, status codes).
module ffsra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffsra_pkg::ctl_sts_t sts,
  output ffsra_pkg::ctl_cmd_t cmd
);

  ffsra_pkg::ctl_state_t state_r, state_nxt;
  logic clear_pend_r, clear_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffsra_pkg::S_SWEEP;
      clear_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clear_pend_r <= clear_pend_nxt;
    end
  end

  assign busy = (state_r != ffsra_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_nxt      = state_r;
    clear_pend_nxt = clear_pend_r;
    unique case (state_r)
      ffsra_pkg::S_SWEEP: begin
        if (sts.sweep_done) begin
          state_nxt      = ffsra_pkg::S_IDLE;
          clear_pend_nxt = 1'b0;
        end
      end
      ffsra_pkg::S_IDLE: begin
        if (start) begin
          if (sts.in_clear) begin
            state_nxt      = ffsra_pkg::S_SWEEP;
            clear_pend_nxt = 1'b1;
          end else begin
            state_nxt = ffsra_pkg::S_BASE;
          end
        end
      end
      ffsra_pkg::S_BASE: begin
        if (!sts.range_ok || sts.base_zero || sts.rooms_zero) begin
          state_nxt = ffsra_pkg::S_IDLE;
        end else begin
          state_nxt = ffsra_pkg::S_SCAN;
        end
      end
      ffsra_pkg::S_SCAN: begin
        if (sts.hit) begin
          state_nxt = ffsra_pkg::S_WRITE;
        end else if (sts.last_room) begin
          state_nxt = ffsra_pkg::S_IDLE;
        end
      end
      ffsra_pkg::S_WRITE: begin
        state_nxt = ffsra_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffsra_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.out_status = ffsra_pkg::STATUS_NO_FIT;
    unique case (state_r)
      ffsra_pkg::S_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (sts.sweep_done && clear_pend_r) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ffsra_pkg::STATUS_CLEARED;
        end
      end
      ffsra_pkg::S_IDLE: begin
        cmd.req_load = start;
      end
      ffsra_pkg::S_BASE: begin
        if (!sts.range_ok || sts.base_zero || sts.rooms_zero) begin
          cmd.out_load = 1'b1;
        end else begin
          cmd.base_load = 1'b1;
        end
      end
      ffsra_pkg::S_SCAN: begin
        if (sts.hit) begin
          cmd.hit_load = 1'b1;
        end else if (sts.last_room) begin
          cmd.out_load = 1'b1;
        end else begin
          cmd.room_next = 1'b1;
        end
      end
      ffsra_pkg::S_WRITE: begin
        cmd.write_en   = 1'b1;
        cmd.out_load   = 1'b1;
        cmd.out_status = ffsra_pkg::STATUS_PLACED;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/ffsra_datapath.sv
// Datapath of the allocator: config registers, busy bitmap memories, free-slot
// masking, lowest-free-slot pick and result register. Depends on ffsra_pkg.
module ffsra_datapath #(
  parameter int MAX_SLOTS    = 64,
  parameter int MAX_ROOMS    = 16,
  parameter int MAX_TEACHERS = 64,
  parameter int MAX_YEARS    = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ffsra_pkg::req_t                     in_req,
  input  logic                                cfg_we,
  input  logic [ffsra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffsra_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  ffsra_pkg::ctl_cmd_t                 cmd,
  output ffsra_pkg::ctl_sts_t                 sts,
  output logic                                out_valid,
  output ffsra_pkg::rsp_t                     out_rsp
);

  localparam int TW = (MAX_TEACHERS > 1) ? $clog2(MAX_TEACHERS) : 1;
  localparam int YW = (MAX_YEARS > 1) ? $clog2(MAX_YEARS) : 1;
  localparam int RW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int KW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SWEEP_TY = (MAX_TEACHERS > MAX_YEARS) ? MAX_TEACHERS : MAX_YEARS;
  localparam int SWEEP_DEPTH = (SWEEP_TY > MAX_ROOMS) ? SWEEP_TY : MAX_ROOMS;
  localparam int SWW = (SWEEP_DEPTH > 1) ? $clog2(SWEEP_DEPTH) : 1;

  logic [MAX_SLOTS-1:0] teacher_mem [MAX_TEACHERS];
  logic [MAX_SLOTS-1:0] year_mem    [MAX_YEARS];
  logic [MAX_SLOTS-1:0] room_mem    [MAX_ROOMS];

  logic [6:0]           num_slots_r;
  logic [4:0]           num_rooms_r;
  ffsra_pkg::req_t      req_r;
  logic [SWW-1:0]       sweep_cnt_r;
  logic [MAX_SLOTS-1:0] tq_r, yq_r, rq_r;
  logic [MAX_SLOTS-1:0] base_r, bit_r;
  logic [RW-1:0]        chk_r;
  logic                 out_valid_r;
  ffsra_pkg::rsp_t      out_r;

  logic [MAX_SLOTS-1:0] mask;
  logic [MAX_SLOTS-1:0] base_nxt;
  logic [MAX_SLOTS-1:0] avail;
  logic [MAX_SLOTS-1:0] low_bit;
  logic [KW-1:0]        slot_idx;
  logic [RW-1:0]        room_rd_addr;
  logic                 room_rd;
  logic                 placed;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_slots_r <= ffsra_pkg::NUM_SLOTS_RESET;
      num_rooms_r <= ffsra_pkg::NUM_ROOMS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffsra_pkg::CFG_NUM_SLOTS: num_slots_r <= cfg_data[6:0];
        ffsra_pkg::CFG_NUM_ROOMS: num_rooms_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep counter; wraps to zero at the end of each pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.sweep_en) begin
      sweep_cnt_r <= sts.sweep_done ? '0 : sweep_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_req;
    end
  end

  // Teacher bitmap memory
  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      if (int'(sweep_cnt_r) < MAX_TEACHERS) begin
        teacher_mem[TW'(sweep_cnt_r)] <= '0;
      end
    end else if (cmd.write_en) begin
      teacher_mem[TW'(req_r.teacher_idx)] <= tq_r | bit_r;
    end
    if (cmd.req_load) begin
      tq_r <= teacher_mem[TW'(in_req.teacher_idx)];
    end
  end

  // Year bitmap memory
  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      if (int'(sweep_cnt_r) < MAX_YEARS) begin
        year_mem[YW'(sweep_cnt_r)] <= '0;
      end
    end else if (cmd.write_en) begin
      year_mem[YW'(req_r.year_id)] <= yq_r | bit_r;
    end
    if (cmd.req_load) begin
      yq_r <= year_mem[YW'(in_req.year_id)];
    end
  end

  // Room bitmap memory; rooms are read one per scan cycle
  assign room_rd      = cmd.base_load | cmd.room_next;
  assign room_rd_addr = cmd.base_load ? '0 : chk_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      if (int'(sweep_cnt_r) < MAX_ROOMS) begin
        room_mem[RW'(sweep_cnt_r)] <= '0;
      end
    end else if (cmd.write_en) begin
      room_mem[chk_r] <= rq_r | bit_r;
    end
    if (room_rd) begin
      rq_r <= room_mem[room_rd_addr];
    end
  end

  // chk_r names the room whose bitmap sits in rq_r
  always_ff @(posedge clk) begin
    if (room_rd) begin
      chk_r <= room_rd_addr;
    end
    if (cmd.base_load) begin
      base_r <= base_nxt;
    end
    if (cmd.hit_load) begin
      bit_r <= low_bit;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      mask[i] = (i < int'(num_slots_r));
    end
  end

  assign base_nxt = mask & ~tq_r & ~yq_r;
  assign avail    = base_r & ~rq_r;
  // isolate the lowest set bit
  assign low_bit  = avail & (~avail + 1'b1);

  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (bit_r[i]) begin
        slot_idx = slot_idx | KW'(i);
      end
    end
  end

  always_comb begin
    sts.in_clear   = in_req.action;
    sts.range_ok   = (int'(req_r.teacher_idx) < MAX_TEACHERS) &&
                     (int'(req_r.year_id) < MAX_YEARS);
    sts.base_zero  = ~|base_nxt;
    sts.rooms_zero = (num_rooms_r == '0);
    sts.hit        = |avail;
    sts.last_room  = (int'(chk_r) + 1 >= int'(num_rooms_r)) ||
                     (int'(chk_r) == MAX_ROOMS - 1);
    sts.sweep_done = (int'(sweep_cnt_r) == SWEEP_DEPTH - 1);
  end

  assign placed = (cmd.out_status == ffsra_pkg::STATUS_PLACED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status     <= cmd.out_status;
      out_r.course_out <= req_r.course_code;
      out_r.room_index <= placed ? 4'(chk_r) : 4'd0;
      out_r.slot_num   <= placed ? 7'(slot_idx) + 7'd1 : 7'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

endmodule

// File: rtl/first_fit_slot_room_allocator_top.sv
// Top level of the first-fit slot and room allocator: controller plus datapath.
// Depends on ffsra_pkg, ffsra_ctrl and ffsra_datapath.
//
// A place request that succeeds forms the free-slot mask from the teacher and
// year bitmaps, checks the room bitmaps in turn from room 0 (1..MAX_ROOMS rooms
// scanned), then writes back and gives its result. One that finds no room gives
// its result after the last room is checked; one that fails on range, an empty
// slot mask or a zero room count gives it without checking any room. A clear
// request runs a clearing pass over max(MAX_TEACHERS, MAX_YEARS, MAX_ROOMS)
// entries of the bitmap memories, one entry per cycle, and its result follows in
// the next cycle; reset runs the same pass with no result. busy is high from the
// accepting edge until the result cycle, so the next request can be taken at the
// edge that ends that cycle. The result strobe out_valid is high for exactly one
// cycle and cannot be held off. Config writes are always taken (cfg_ready is tied
// high) but must only be issued while idle.
module first_fit_slot_room_allocator_top #(
  parameter int MAX_SLOTS    = 64,
  parameter int MAX_ROOMS    = 16,
  parameter int MAX_TEACHERS = 64,
  parameter int MAX_YEARS    = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  ffsra_pkg::req_t                  in_req,
  output logic                             out_valid,
  output ffsra_pkg::rsp_t                  out_rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ffsra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffsra_pkg::CFG_DATA_W-1:0] cfg_data
);

  ffsra_pkg::ctl_cmd_t cmd;
  ffsra_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  ffsra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ffsra_datapath #(
    .MAX_SLOTS    (MAX_SLOTS),
    .MAX_ROOMS    (MAX_ROOMS),
    .MAX_TEACHERS (MAX_TEACHERS),
    .MAX_YEARS    (MAX_YEARS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

`ifndef NO_ASSERTIONS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make block busy");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != ffsra_pkg::STATUS_PLACED) |->
      (out_rsp.room_index == 4'd0 && out_rsp.slot_num == 7'd0))
    else $error("room or slot nonzero on unplaced result");

  a_placed_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ffsra_pkg::STATUS_PLACED) |->
      (out_rsp.slot_num != 7'd0))
    else $error("placed result with slot zero");
`endif

endmodule
